### src/rhc_pkg.sv
// Shared types, constants and the divide step of the RGB to HSL converter.
`default_nettype none
package rhc_pkg;

    localparam int CHAN_W         = 8;
    localparam int FRAC_W         = 16;
    localparam int DVS_W          = 11;
    localparam int REM_W          = 11;
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = FRAC_W / BITS_PER_STAGE;
    // two front stages, the divide stages, one output stage
    localparam int NUM_STAGES     = DIV_STAGES + 3;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } pixel_t;

    typedef struct packed {
        logic [FRAC_W-1:0] hue;
        logic [FRAC_W-1:0] saturation;
        logic [FRAC_W-1:0] lightness;
        logic [CHAN_W-1:0] alpha_out;
    } hsl_t;

    // quo starts as the low numerator bits and fills with quotient bits
    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [FRAC_W-1:0] quo;
        logic [DVS_W-1:0]  dvs;
    } div_lane_t;

    typedef struct packed {
        div_lane_t         hue_lane;
        div_lane_t         sat_lane;
        logic [FRAC_W-1:0] lightness;
        logic [CHAN_W-1:0] alpha;
        logic              grey;
    } div_beat_t;

    // One restoring division step: one quotient bit.
    function automatic div_lane_t div_step(input div_lane_t lane);
        logic [REM_W:0] part;
        logic [REM_W:0] dvs_ext;
        div_lane_t      res;
        part    = {lane.rem, lane.quo[FRAC_W-1]};
        dvs_ext = {1'b0, lane.dvs};
        res.dvs = lane.dvs;
        if (part >= dvs_ext)
        begin
            res.rem = REM_W'(part - dvs_ext);
            res.quo = {lane.quo[FRAC_W-2:0], 1'b1};
        end
        else
        begin
            res.rem = part[REM_W-1:0];
            res.quo = {lane.quo[FRAC_W-2:0], 1'b0};
        end
        return res;
    endfunction

endpackage
`default_nettype wire

### src/rhc_front.sv
// Front stages: channel max/min, then sums, lightness and divider operands.
`default_nettype none
module rhc_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire rhc_pkg::pixel_t pixel,
    input  wire logic            pixel_valid,
    input  wire logic [1:0]      en,
    output rhc_pkg::div_beat_t   beat,
    output logic [1:0]           valid
);

    rhc_pkg::pixel_t                  pix_reg;
    logic [rhc_pkg::CHAN_W-1:0]       max_reg;
    logic [rhc_pkg::CHAN_W-1:0]       min_reg;
    logic [rhc_pkg::CHAN_W-1:0]       max_next;
    logic [rhc_pkg::CHAN_W-1:0]       min_next;
    logic [1:0]                       valid_reg;
    rhc_pkg::div_beat_t               beat_reg;
    rhc_pkg::div_beat_t               beat_next;

    logic [rhc_pkg::CHAN_W-1:0]       diff;
    logic [rhc_pkg::CHAN_W:0]         sum;
    logic [rhc_pkg::CHAN_W-1:0]       den;
    logic [rhc_pkg::CHAN_W+8:0]       light_wide;
    logic [rhc_pkg::DVS_W-1:0]        d2;
    logic [rhc_pkg::DVS_W-1:0]        d4;
    logic [rhc_pkg::DVS_W-1:0]        d6;
    logic [rhc_pkg::DVS_W-1:0]        off_term;
    logic [rhc_pkg::CHAN_W-1:0]       minuend;
    logic [rhc_pkg::CHAN_W-1:0]       subtrahend;
    logic [rhc_pkg::DVS_W-1:0]        num;

    // find largest and smallest channel
    always_comb
    begin
        max_next = pixel.red;
        min_next = pixel.red;
        if (pixel.green > max_next)
        begin
            max_next = pixel.green;
        end
        if (pixel.blue > max_next)
        begin
            max_next = pixel.blue;
        end
        if (pixel.green < min_next)
        begin
            min_next = pixel.green;
        end
        if (pixel.blue < min_next)
        begin
            min_next = pixel.blue;
        end
    end

    // lightness is sum * 65535 / 510 = sum * 257 / 2; sector picks hue numerator
    always_comb
    begin
        diff       = max_reg - min_reg;
        sum        = {1'b0, max_reg} + {1'b0, min_reg};
        den        = (sum > 9'd255) ? 8'(9'd510 - sum) : sum[rhc_pkg::CHAN_W-1:0];
        light_wide = {sum, 8'd0} + {8'd0, sum};
        d2         = {2'b00, diff, 1'b0};
        d4         = {1'b0, diff, 2'b00};
        d6         = d2 + d4;
        if (max_reg == pix_reg.red)
        begin
            minuend    = pix_reg.green;
            subtrahend = pix_reg.blue;
            off_term   = (pix_reg.green < pix_reg.blue) ? d6 : '0;
        end
        else if (max_reg == pix_reg.green)
        begin
            minuend    = pix_reg.blue;
            subtrahend = pix_reg.red;
            off_term   = d2;
        end
        else
        begin
            minuend    = pix_reg.red;
            subtrahend = pix_reg.green;
            off_term   = d4;
        end
        num = {3'b000, minuend} + off_term - {3'b000, subtrahend};

        beat_next.hue_lane.rem = num;
        beat_next.hue_lane.quo = '0;
        beat_next.hue_lane.dvs = d6;
        // diff * 65535 = (diff - 1) * 65536 + (65536 - diff)
        beat_next.sat_lane.rem = {3'b000, 8'(diff - 8'd1)};
        beat_next.sat_lane.quo = 16'd0 - {8'd0, diff};
        beat_next.sat_lane.dvs = {3'b000, den};
        beat_next.lightness    = light_wide[16:1];
        beat_next.alpha        = pix_reg.alpha;
        beat_next.grey         = (diff == '0);
    end

    // advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= pixel_valid;
            end
            if (en[1])
            begin
                valid_reg[1] <= valid_reg[0];
            end
        end
    end

    // advance payload
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            pix_reg <= pixel;
            max_reg <= max_next;
            min_reg <= min_next;
        end
        if (en[1])
        begin
            beat_reg <= beat_next;
        end
    end

    assign beat  = beat_reg;
    assign valid = valid_reg;

endmodule
`default_nettype wire

### src/rhc_div_stage.sv
// One divide stage: two quotient bits for both hue and saturation.
`default_nettype none
module rhc_div_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               valid_in,
    input  wire rhc_pkg::div_beat_t beat_in,
    input  wire logic               en,
    output logic                    valid_out,
    output rhc_pkg::div_beat_t      beat_out
);

    logic               valid_reg;
    rhc_pkg::div_beat_t beat_reg;
    rhc_pkg::div_beat_t beat_next;

    // run the division steps of this stage
    always_comb
    begin
        beat_next = beat_in;
        for (int i = 0; i < rhc_pkg::BITS_PER_STAGE; i++)
        begin
            beat_next.hue_lane = rhc_pkg::div_step(beat_next.hue_lane);
            beat_next.sat_lane = rhc_pkg::div_step(beat_next.sat_lane);
        end
    end

    // advance valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    // advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            beat_reg <= beat_next;
        end
    end

    assign valid_out = valid_reg;
    assign beat_out  = beat_reg;

endmodule
`default_nettype wire

### src/rhc_out.sv
// Output register: zero hue and saturation of grey pixels and hold the result.
`default_nettype none
module rhc_out (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               valid_in,
    input  wire rhc_pkg::div_beat_t beat_in,
    input  wire logic               en,
    output logic                    valid_out,
    output rhc_pkg::hsl_t           result
);

    logic          valid_reg;
    rhc_pkg::hsl_t result_reg;
    rhc_pkg::hsl_t result_next;

    // drop quotients of grey pixels
    always_comb
    begin
        result_next.hue        = beat_in.grey ? '0 : beat_in.hue_lane.quo;
        result_next.saturation = beat_in.grey ? '0 : beat_in.sat_lane.quo;
        result_next.lightness  = beat_in.lightness;
        result_next.alpha_out  = beat_in.alpha;
    end

    // advance valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    // hold result while stalled
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
        end
    end

    assign valid_out = valid_reg;
    assign result    = result_reg;

endmodule
`default_nettype wire

### src/rgb_to_hsl_converter_core.sv
// RGB to HSL converter: pixel in, hue/saturation/lightness out, fully pipelined.
//
// Input channel: pixel_valid, pixel_stall, pixel (red, green, blue, alpha bytes).
// Output channel: result_valid, result_stall, result (hue, saturation,
// lightness as 16-bit fractions, alpha_out copied from alpha).
// A beat moves on a rising edge where valid is high and stall is low.
// A pixel accepted on an edge passes through eleven register stages before it
// shows on result (two front stages, eight divide stages of two quotient bits
// each, one output register); a stall holds it in its stage.
// Throughput: one pixel per cycle while pixel_stall is low; the restoring
// divide pipeline for hue and saturation sets the depth.
// Each stage advances when it is empty or the stage after it advances, so
// while result_stall is high, bubbles inside the pipeline still close up and
// new pixels are taken until every stage holds a beat; then pixel_stall rises.
// Nothing is lost or repeated during a stall.
// Reset (rst_n low) empties the pipeline: all valid bits clear at once.
`default_nettype none
module rgb_to_hsl_converter_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            pixel_valid,
    output logic                 pixel_stall,
    input  wire rhc_pkg::pixel_t pixel,
    output logic                 result_valid,
    input  wire logic            result_stall,
    output rhc_pkg::hsl_t        result
);

    logic [rhc_pkg::NUM_STAGES-1:0] valid;
    logic [rhc_pkg::NUM_STAGES:0]   en;
    rhc_pkg::div_beat_t             beat [0:rhc_pkg::DIV_STAGES];

    // a stage loads when empty or when its successor loads
    always_comb
    begin
        en[rhc_pkg::NUM_STAGES] = !result_stall;
        for (int k = rhc_pkg::NUM_STAGES - 1; k >= 0; k--)
        begin
            en[k] = !valid[k] || en[k+1];
        end
    end

    assign pixel_stall  = !en[0];
    assign result_valid = valid[rhc_pkg::NUM_STAGES-1];

    rhc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel       (pixel),
        .pixel_valid (pixel_valid),
        .en          (en[1:0]),
        .beat        (beat[0]),
        .valid       (valid[1:0])
    );

    for (genvar s = 0; s < rhc_pkg::DIV_STAGES; s++)
    begin : g_div
        rhc_div_stage u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (valid[s+1]),
            .beat_in   (beat[s]),
            .en        (en[s+2]),
            .valid_out (valid[s+2]),
            .beat_out  (beat[s+1])
        );
    end

    rhc_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (valid[rhc_pkg::NUM_STAGES-2]),
        .beat_in   (beat[rhc_pkg::DIV_STAGES]),
        .en        (en[rhc_pkg::NUM_STAGES-1]),
        .valid_out (valid[rhc_pkg::NUM_STAGES-1]),
        .result    (result)
    );

endmodule
`default_nettype wire

### tb/hsl_checker.sv
// Checker for the RGB to HSL converter: predicts each result and compares it field by field.
module hsl_checker
    import rhc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   pixel_valid,
    input  wire logic   pixel_stall,
    input  wire pixel_t pixel,
    input  wire logic   result_valid,
    input  wire logic   result_stall,
    input  wire hsl_t   result,
    output int          mismatches,
    output int          outstanding,
    output int          checked
);

    localparam longint FULL_TURN  = longint'(1) << FRAC_W;
    localparam longint FRAC_UNIT  = FULL_TURN - 1;
    localparam int     LIGHT_DIV  = 510;
    localparam int     MID_SUM    = 255;
    localparam int     SECTORS    = 6;
    // sector offsets, in units of the channel spread
    localparam int     OFF_RED_WRAP = 6;
    localparam int     OFF_GREEN    = 2;
    localparam int     OFF_BLUE     = 4;

    hsl_t pending_hsl [$];

    // Convert one pixel; every quotient truncates.
    function automatic hsl_t predict_hsl(input pixel_t px);
        int   r;
        int   g;
        int   b;
        int   mx;
        int   mn;
        int   sum;
        int   spread;
        int   den;
        int   chan;
        int   off;
        int   num;
        hsl_t res;
        r = px.red;
        g = px.green;
        b = px.blue;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        sum = mx + mn;
        res.hue        = '0;
        res.saturation = '0;
        res.lightness  = FRAC_W'((longint'(sum) * FRAC_UNIT) / LIGHT_DIV);
        res.alpha_out  = px.alpha;
        // grey pixels keep hue and saturation at zero
        if (mx != mn)
        begin
            spread = mx - mn;
            den = (sum > MID_SUM) ? (LIGHT_DIV - sum) : sum;
            res.saturation = FRAC_W'((longint'(spread) * FRAC_UNIT) / den);
            // pick the sector: red wins ties, then green
            if (mx == r)
            begin
                chan = g - b;
                off  = (g < b) ? OFF_RED_WRAP : 0;
            end
            else if (mx == g)
            begin
                chan = b - r;
                off  = OFF_GREEN;
            end
            else
            begin
                chan = r - g;
                off  = OFF_BLUE;
            end
            num = chan + off * spread;
            if (num < 0)
                num = 0;
            res.hue = FRAC_W'((longint'(num) * FULL_TURN) / (SECTORS * spread));
        end
        return res;
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Check result beats against the oldest prediction, then queue new pixel beats.
    always @(posedge clk or negedge rst_n)
    begin
        hsl_t want;
        if (!rst_n)
        begin
            pending_hsl.delete();
            mismatches  = 0;
            checked     = 0;
            outstanding <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (pending_hsl.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result beat: hue %0d sat %0d light %0d alpha %0d",
                             $time, result.hue, result.saturation, result.lightness,
                             result.alpha_out);
                end
                else
                begin
                    want = pending_hsl.pop_front();
                    checked++;
                    compare_field("hue", want.hue, result.hue);
                    compare_field("saturation", want.saturation, result.saturation);
                    compare_field("lightness", want.lightness, result.lightness);
                    compare_field("alpha_out", want.alpha_out, result.alpha_out);
                end
            end
            if (pixel_valid && !pixel_stall)
                pending_hsl.push_back(predict_hsl(pixel));
            outstanding <= pending_hsl.size();
        end
    end

endmodule

### tb/testbench.sv
// Top of the RGB to HSL converter testbench: clock, reset, pixel stimulus and verdict.
module testbench;
    import rhc_pkg::*;

    localparam int RANDOM_PIXELS = 2000;
    localparam int PHASE_LEN     = 150;
    localparam int NUM_DIRECTED  = 24;

    logic   clk;
    logic   rst_n;
    logic   pixel_valid;
    logic   pixel_stall;
    pixel_t pixel;
    logic   result_valid;
    logic   result_stall;
    hsl_t   result;

    int     mismatches;
    int     outstanding;
    int     checked;
    int     pixels_sent;
    int     grey_sent;
    logic   tx_calm;
    logic   rx_calm;

    // pixels as 0xRRGGBBAA
    logic [31:0] directed_px [NUM_DIRECTED] = '{
        32'h000000_00, 32'hFFFFFF_FF, 32'hFF0000_80, 32'h00FF00_7F,
        32'h0000FF_01, 32'hFFFF00_FE, 32'h00FFFF_55, 32'hFF00FF_AA,
        32'h808080_40, 32'hFF000A_10, 32'hFF0A00_20, 32'h7F0000_33,
        32'hFF0101_44, 32'h80807F_66, 32'h808081_99, 32'h010000_C3,
        32'hFFFFFE_3C, 32'h00FF01_0F, 32'h0100FF_F0, 32'hAA55AA_5A,
        32'h55AA55_A5, 32'hFEFEFE_7E, 32'h010101_81, 32'h00FF00_FF
    };

    rgb_to_hsl_converter_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    hsl_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .checked      (checked)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Gap length: mostly none or short, a few long; none in calm phases.
    function automatic int pick_gap(input logic calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 8);
        else
            return $urandom_range(15, 40);
    endfunction

    function automatic logic [7:0] corner_byte();
        case ($urandom_range(0, 4))
            0:       return 8'h00;
            1:       return 8'h01;
            2:       return 8'hFE;
            3:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Mix plain random pixels with greys, ties, corners and narrow spreads.
    function automatic pixel_t random_pixel();
        pixel_t     px;
        logic [7:0] base;
        px = pixel_t'($urandom);
        case ($urandom_range(0, 9))
            4:
            begin
                px.green = px.red;
                px.blue  = px.red;
            end
            5:
            begin
                case ($urandom_range(0, 2))
                    0:       px.green = px.red;
                    1:       px.blue  = px.red;
                    default: px.blue  = px.green;
                endcase
            end
            6:
            begin
                px.red   = corner_byte();
                px.green = corner_byte();
                px.blue  = corner_byte();
            end
            7:
            begin
                base     = 8'($urandom);
                px.red   = base;
                px.green = base + 8'($urandom_range(0, 2));
                px.blue  = base - 8'($urandom_range(0, 2));
            end
            default:
            begin
            end
        endcase
        return px;
    endfunction

    // Drive one pixel beat after a gap and hold it until accepted.
    task automatic send_pixel(input pixel_t px, input int gap);
        repeat (gap)
        begin
            @(negedge clk);
            pixel_valid = 1'b0;
        end
        @(negedge clk);
        pixel_valid = 1'b1;
        pixel       = px;
        @(posedge clk);
        while (pixel_stall)
            @(posedge clk);
        pixels_sent++;
        if (px.red == px.green && px.green == px.blue)
            grey_sent++;
    endtask

    // Drop valid and hold off until every predicted result has come back.
    task automatic wait_drained();
        @(negedge clk);
        pixel_valid = 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Receiver side: random stall pattern, redrawn after each hold period.
    initial
    begin
        int hold;
        int r;
        hold         = 0;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
                hold--;
            else
            begin
                r = $urandom_range(0, 99);
                if (rx_calm || r < 65)
                begin
                    result_stall = 1'b0;
                    hold = $urandom_range(0, 5);
                end
                else if (r < 95)
                begin
                    result_stall = 1'b1;
                    hold = $urandom_range(0, 3);
                end
                else
                begin
                    result_stall = 1'b1;
                    hold = $urandom_range(10, 40);
                end
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin
        rst_n       = 1'b0;
        pixel_valid = 1'b0;
        pixel       = '0;
        tx_calm     = 1'b0;
        rx_calm     = 1'b0;
        pixels_sent = 0;
        grey_sent   = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed corners and sectors
        foreach (directed_px[i])
            send_pixel(pixel_t'(directed_px[i]), pick_gap(1'b0));
        wait_drained();

        // random pixels in phases, some with no idling on one or both sides
        for (int i = 0; i < RANDOM_PIXELS; i++)
        begin
            if (i % PHASE_LEN == 0)
            begin
                tx_calm = ($urandom_range(0, 3) == 0);
                rx_calm = ($urandom_range(0, 3) == 0);
            end
            if (i == RANDOM_PIXELS / 2)
                wait_drained();
            send_pixel(random_pixel(), pick_gap(tx_calm));
        end
        wait_drained();
        repeat (NUM_STAGES + 8) @(posedge clk);

        $display("Sent %0d pixels (%0d directed, %0d grey) with random gaps and stalls.",
                 pixels_sent, NUM_DIRECTED, grey_sent);
        $display("Checked %0d results, %0d mismatches, %0d still pending.",
                 checked, mismatches, outstanding);
        if (mismatches == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
